>>> rtl/nket_pkg.sv
// Shared types and constants for the name-keyed entry table.
// No dependencies; imported by the top level and nket_match.
`default_nettype none

package nket_pkg;

   // Fixed field widths
   localparam int OPCODE_W   = 2;
   localparam int KEY_W      = 64;
   localparam int SECTOR_W   = 10;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 16;

   // Parameter defaults
   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int DEF_NAME_BYTES    = 8;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Scan outcome flags handed from the match unit to the sequencer
   typedef struct packed {
      logic hit;    // a valid slot holds the key
      logic free;   // at least one slot is not valid
   } match_flags_type;

endpackage : nket_pkg

`default_nettype wire

>>> rtl/name_keyed_entry_table_top.sv
// Top level of the name-keyed entry table: request sequencer, slot valid
// bits, name/sector RAM and result register. Depends on nket_pkg,
// nket_ram and nket_match.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | opcode, key_name, new_sector
//   rsp     | out | rsp_tvalid/rsp_tready  | status, found_sector, slot_index
//
// After acceptance, one RAM read per slot feeds the single name compare
// unit, then the update state applies the change and the hold state loads
// the result register once it is free or being emptied.
// Reset clears the valid bits; name and sector RAM contents need no reset.
// req_tready is high only while the sequencer is idle. A result waiting on
// rsp_tready does not block the next item until that item's result is due.
`default_nettype none

module name_keyed_entry_table_top #(
   parameter int TABLE_ENTRIES = nket_pkg::DEF_TABLE_ENTRIES,
   parameter int NAME_BYTES    = nket_pkg::DEF_NAME_BYTES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: opcode[1:0], key_name[65:2], new_sector[75:66], zero pad
   input  wire logic [nket_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: status[1:0], found_sector[11:2], slot_index[15:12]
   output logic      [nket_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready
);

   import nket_pkg::*;

   localparam int NAME_W = 8 * NAME_BYTES;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int MEM_W  = NAME_W + SECTOR_W;
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_HOLD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Request fields
   logic [OPCODE_W-1:0] req_opcode;
   logic [KEY_W-1:0]    req_key;
   logic [SECTOR_W-1:0] req_sector;
   logic [NAME_W-1:0]   norm_name;
   logic                req_take;

   // Captured request
   logic [OPCODE_W-1:0] opcode_ff;
   logic [NAME_W-1:0]   key_ff;
   logic [SECTOR_W-1:0] sector_ff;

   // Scan control
   logic [CNT_W-1:0]    scan_cnt_ff, scan_cnt_in;
   logic                scan_issue;
   logic                cmp_vld_ff;
   logic [IDX_W-1:0]    cmp_idx_ff;

   // Slot valid bits
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;

   // RAM ports
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [MEM_W-1:0]    rd_data;

   // Match unit results
   match_flags_type     flags;
   logic [IDX_W-1:0]    hit_idx;
   logic [SECTOR_W-1:0] hit_sector;
   logic [IDX_W-1:0]    free_idx;

   // Result computation
   logic [STATUS_W-1:0]   res_status_in, res_status_ff;
   logic [SECTOR_W-1:0]   res_sector_in, res_sector_ff;
   logic [SLOT_OUT_W-1:0] res_slot_in, res_slot_ff;
   logic                  rsp_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_opcode = req_tdata[OPCODE_W-1:0];
   assign req_key    = req_tdata[OPCODE_W +: KEY_W];
   assign req_sector = req_tdata[OPCODE_W+KEY_W +: SECTOR_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Name normalization: keep bytes up to the first NUL
   always_comb begin
      logic live;
      live      = 1'b1;
      norm_name = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (req_key[8*b +: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            norm_name[8*b +: 8] = req_key[8*b +: 8];
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff <= req_opcode;
         key_ff    <= norm_name;
         sector_ff <= req_sector;
      end
   end

   // Scan address counter
   assign scan_issue = (state_ff == S_SCAN) && (scan_cnt_ff != SCAN_END);

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      if (req_take) begin
         scan_cnt_in = '0;
      end else if (scan_issue) begin
         scan_cnt_in = scan_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         cmp_vld_ff  <= 1'b0;
      end else begin
         scan_cnt_ff <= scan_cnt_in;
         cmp_vld_ff  <= scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_cnt_ff[IDX_W-1:0];
   end

   // Name and sector store
   assign wr_addr = free_idx;

   nket_ram #(
      .WIDTH (MEM_W),
      .DEPTH (TABLE_ENTRIES),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({sector_ff, key_ff}),
      .rd_en  (scan_issue),
      .rd_addr(scan_cnt_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   // Shared compare unit
   nket_match #(
      .NAME_W(NAME_W),
      .IDX_W (IDX_W)
   ) u_match (
      .clock         (clock),
      .reset         (reset),
      .clear         (req_take),
      .cmp_en        (cmp_vld_ff),
      .cmp_idx       (cmp_idx_ff),
      .cmp_slot_valid(slot_valid_ff[cmp_idx_ff]),
      .cmp_name      (rd_data[NAME_W-1:0]),
      .cmp_sector    (rd_data[NAME_W +: SECTOR_W]),
      .key           (key_ff),
      .flags         (flags),
      .hit_idx       (hit_idx),
      .hit_sector    (hit_sector),
      .free_idx      (free_idx)
   );

   // Update decision: result fields, RAM write, valid bit change
   always_comb begin
      res_status_in = ST_NOT_FOUND;
      res_sector_in = '0;
      res_slot_in   = '0;
      wr_en         = 1'b0;
      slot_valid_in = slot_valid_ff;
      case (opcode_ff)
         OP_FIND: begin
            if (flags.hit) begin
               res_status_in = ST_OK;
               res_sector_in = hit_sector;
               res_slot_in   = SLOT_OUT_W'(hit_idx);
            end
         end
         OP_ADD: begin
            if (flags.hit) begin
               res_status_in = ST_DUPLICATE;
            end else if (flags.free) begin
               res_status_in = ST_OK;
               res_slot_in   = SLOT_OUT_W'(free_idx);
               wr_en         = (state_ff == S_UPDATE);
               slot_valid_in[free_idx] = 1'b1;
            end else begin
               res_status_in = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (flags.hit) begin
               res_status_in = ST_OK;
               res_slot_in   = SLOT_OUT_W'(hit_idx);
               slot_valid_in[hit_idx] = 1'b0;
            end
         end
         default: begin
            res_status_in = ST_NOT_FOUND;
         end
      endcase
   end

   // Valid bits change only in the update cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (state_ff == S_UPDATE) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Result held until the output register is free
   always_ff @(posedge clock) begin
      if (state_ff == S_UPDATE) begin
         res_status_ff <= res_status_in;
         res_sector_ff <= res_sector_in;
         res_slot_ff   <= res_slot_in;
      end
   end

   // Sequencer
   assign rsp_load = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!scan_issue) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {res_slot_ff, res_sector_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : name_keyed_entry_table_top

`default_nettype wire

>>> rtl/nket_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nket_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : nket_ram

`default_nettype wire

>>> rtl/nket_match.sv
// Shared compare unit: checks one slot per cycle against the key and keeps
// the first matching slot and the first free slot. Depends on nket_pkg.
`default_nettype none

module nket_match #(
   parameter int NAME_W = 64,
   parameter int IDX_W  = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         clear,
   input  wire logic                         cmp_en,
   input  wire logic [IDX_W-1:0]             cmp_idx,
   input  wire logic                         cmp_slot_valid,
   input  wire logic [NAME_W-1:0]            cmp_name,
   input  wire logic [nket_pkg::SECTOR_W-1:0] cmp_sector,
   input  wire logic [NAME_W-1:0]            key,
   output nket_pkg::match_flags_type         flags,
   output logic      [IDX_W-1:0]             hit_idx,
   output logic      [nket_pkg::SECTOR_W-1:0] hit_sector,
   output logic      [IDX_W-1:0]             free_idx
);

   import nket_pkg::*;

   logic                hit_ff, hit_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [SECTOR_W-1:0] hit_sector_ff, hit_sector_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                is_hit;
   logic                is_free;

   // One name compare per cycle
   assign is_hit  = cmp_en && cmp_slot_valid && (cmp_name == key);
   assign is_free = cmp_en && !cmp_slot_valid;

   // Keep only the lowest hit and lowest free slot
   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_sector_in = hit_sector_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      if (clear) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (is_hit && !hit_ff) begin
            hit_in        = 1'b1;
            hit_idx_in    = cmp_idx;
            hit_sector_in = cmp_sector;
         end
         if (is_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff    <= hit_idx_in;
      hit_sector_ff <= hit_sector_in;
      free_idx_ff   <= free_idx_in;
   end

   assign flags.hit  = hit_ff;
   assign flags.free = free_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_sector = hit_sector_ff;
   assign free_idx   = free_idx_ff;

endmodule : nket_match

`default_nettype wire

>>> verif/tb_name_keyed_entry_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for name_keyed_entry_table_top: directed table rows, then
// random find/add/remove traffic checked against an in-bench directory predictor.
// Depends on nket_pkg and the name_keyed_entry_table_top RTL.

module tb_name_keyed_entry_table_top;
   import nket_pkg::*;

   localparam int ENTRIES   = DEF_TABLE_ENTRIES;
   localparam int KEY_BYTES = DEF_NAME_BYTES;
   localparam int POOL_SIZE = 24;
   localparam int SEGMENTS  = 10;
   localparam int SEG_ITEMS = 95;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // result item, laid out as rsp_tdata
   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic [SECTOR_W-1:0]   sector;
      logic [STATUS_W-1:0]   status;
   } rsp_item_type;

   // directed stimulus row; typed rows carry a hand-written expectation
   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [KEY_W-1:0]    key;
      logic [SECTOR_W-1:0] sec;
      bit                  typed;
      rsp_item_type        want;
   } dir_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;

   // predictor copy of the directory
   logic                slot_used [ENTRIES];
   logic [KEY_W-1:0]    slot_key  [ENTRIES];
   logic [SECTOR_W-1:0] slot_sec  [ENTRIES];

   rsp_item_type pending_results[$];
   dir_row_type  directed_rows[$];
   logic [63:0]  name_pool[POOL_SIZE];
   int           name_len[POOL_SIZE];
   bit           quiet = 1'b0;
   int           fail_count = 0;
   int           n_items = 0, n_hits = 0, n_added = 0, n_removed = 0;
   int           n_miss = 0, n_dup = 0, n_full = 0;

   name_keyed_entry_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   // keep bytes up to the first NUL, zero the rest
   function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] kept;
      logic             ended;
      kept  = '0;
      ended = 1'b0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
         if (!ended) kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
   endfunction

   // apply one request to the predicted directory, return its result
   function automatic rsp_item_type directory_apply(input logic [OPCODE_W-1:0] op,
                                                    input logic [KEY_W-1:0] raw,
                                                    input logic [SECTOR_W-1:0] sec);
      rsp_item_type     r;
      logic [KEY_W-1:0] key;
      int               hit;
      key = trim_name(raw);
      hit = -1;
      r   = '{slot: '0, sector: '0, status: ST_NOT_FOUND};
      for (int i = ENTRIES - 1; i >= 0; i--)
         if (slot_used[i] && slot_key[i] == key) hit = i;
      case (op)
         OP_FIND: if (hit >= 0) begin
            r.status = ST_OK;
            r.sector = slot_sec[hit];
            r.slot   = SLOT_OUT_W'(hit);
         end
         OP_ADD: if (hit >= 0) begin
            r.status = ST_DUPLICATE;
         end else begin
            r.status = ST_FULL;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!slot_used[i] && r.status == ST_FULL) begin
                  slot_used[i] = 1'b1;
                  slot_key[i]  = key;
                  slot_sec[i]  = sec;
                  r.status     = ST_OK;
                  r.slot       = SLOT_OUT_W'(i);
               end
            end
         end
         OP_REMOVE: if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            r.status       = ST_OK;
            r.slot         = SLOT_OUT_W'(hit);
         end
         default: ;
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones, none in quiet stretches
   function automatic int pick_gap(input int longest);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, longest);
   endfunction

   function automatic void push_row(input logic [OPCODE_W-1:0] op,
                                    input logic [KEY_W-1:0] key,
                                    input logic [SECTOR_W-1:0] sec, input bit typed,
                                    input logic [STATUS_W-1:0] st,
                                    input logic [SECTOR_W-1:0] fs,
                                    input logic [SLOT_OUT_W-1:0] sl);
      dir_row_type row;
      row.op    = op;
      row.key   = key;
      row.sec   = sec;
      row.typed = typed;
      row.want  = '{slot: sl, sector: fs, status: st};
      directed_rows.push_back(row);
   endfunction

   // pool entry, sometimes with junk after the NUL, sometimes a raw random key
   function automatic logic [KEY_W-1:0] pick_name();
      int               k;
      int               r;
      logic [KEY_W-1:0] junk;
      k    = $urandom_range(0, POOL_SIZE - 1);
      r    = $urandom_range(0, 99);
      junk = {$urandom, $urandom};
      if (r < 80 || name_len[k] > 6) return name_pool[k];
      if (r < 90) return name_pool[k] | (junk & ({KEY_W{1'b1}} << (8 * (name_len[k] + 1))));
      return junk;
   endfunction

   // drive one request item, predict its result on acceptance
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [SECTOR_W-1:0] sec, input bit typed,
                            input rsp_item_type want);
      int           gap;
      rsp_item_type predicted;
      gap = pick_gap(40);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {4'b0, sec, key, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = directory_apply(op, key, sec);
      if (typed) predicted = want;
      pending_results.push_back(predicted);
      n_items++;
      case (predicted.status)
         ST_OK: begin
            if (op == OP_FIND) n_hits++;
            else if (op == OP_ADD) n_added++;
            else n_removed++;
         end
         ST_NOT_FOUND: n_miss++;
         ST_DUPLICATE: n_dup++;
         default:      n_full++;
      endcase
   endtask

   // result side backpressure
   initial begin : rsp_stall
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            if (quiet || $urandom_range(0, 2) != 0) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(1, 8);
            end else begin
               rsp_tready <= 1'b0;
               hold = pick_gap(60) + 1;
            end
         end
         hold--;
      end
   end

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result status=%0d sector=%0d slot=%0d",
                        $realtime, got.status, got.sector, got.slot);
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.sector !== want.sector ||
                got.slot !== want.slot) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: mismatch exp status=%0d sector=%0d slot=%0d, got %0d/%0d/%0d",
                           $realtime, want.status, want.sector, want.slot,
                           got.status, got.sector, got.slot);
            end
         end
      end
   end

   initial begin : stimulus
      rsp_item_type none;
      logic [OPCODE_W-1:0] op;
      int r, add_w, rem_w;
      none = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_used[i] = 1'b0;
         slot_key[i]  = '0;
         slot_sec[i]  = '0;
      end

      // directed rows: empty table, extremes, NUL handling, fill, full cases
      push_row(OP_FIND,   64'h41, 10'd5, 1, ST_NOT_FOUND, 10'd0, 4'd0);
      push_row(OP_UNUSED, 64'h0123_4567_89AB_CDEF, 10'h2AA, 1, ST_NOT_FOUND, 10'd0, 4'd0);
      push_row(OP_ADD,    {64{1'b1}}, 10'd1023, 1, ST_OK, 10'd0, 4'd0);
      push_row(OP_FIND,   {64{1'b1}}, 10'd0, 1, ST_OK, 10'd1023, 4'd0);
      push_row(OP_ADD,    64'h0, 10'd0, 1, ST_OK, 10'd0, 4'd1);
      push_row(OP_ADD,    {64{1'b1}}, 10'd77, 1, ST_DUPLICATE, 10'd0, 4'd0);
      push_row(OP_ADD,    64'hDEAD_BEEF_0041_4242, 10'h200, 1, ST_OK, 10'd0, 4'd2);
      push_row(OP_FIND,   64'h0000_0000_0041_4242, 10'd0, 0, ST_OK, 10'd0, 4'd0);
      push_row(OP_REMOVE, 64'h0000_0000_0041_4242, 10'd0, 0, ST_OK, 10'd0, 4'd0);
      for (int i = 0; i < ENTRIES - 2; i++)
         push_row(OP_ADD, {48'h0, 8'h30 + 8'(i), 8'h46}, SECTOR_W'(i * 73 + 1), 0,
                  ST_OK, 10'd0, 4'd0);
      push_row(OP_ADD,    64'h5A5A, 10'd9, 1, ST_FULL, 10'd0, 4'd0);
      push_row(OP_ADD,    {64{1'b1}}, 10'd9, 1, ST_DUPLICATE, 10'd0, 4'd0);
      push_row(OP_REMOVE, 64'hFF00, 10'd0, 1, ST_OK, 10'd0, 4'd1);

      // random name pool: one to eight non-NUL bytes
      for (int k = 0; k < POOL_SIZE; k++) begin
         name_len[k]  = $urandom_range(1, KEY_BYTES);
         name_pool[k] = '0;
         for (int b = 0; b < name_len[k]; b++)
            name_pool[k][8*b +: 8] = 8'($urandom_range(1, 255));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].sec,
                   directed_rows[i].typed, directed_rows[i].want);

      // random traffic in segments that fill, drain or churn the table
      for (int s = 0; s < SEGMENTS; s++) begin
         quiet = (s % 4 == 3);
         add_w = (s % 3 == 0) ? 60 : (s % 3 == 1) ? 15 : 30;
         rem_w = (s % 3 == 0) ? 10 : (s % 3 == 1) ? 45 : 25;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) op = OP_UNUSED;
            else if (r < 3 + add_w) op = OP_ADD;
            else if (r < 3 + add_w + rem_w) op = OP_REMOVE;
            else op = OP_FIND;
            send_item(op, pick_name(), SECTOR_W'($urandom), 0, none);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      quiet = 1'b1;

      wait (pending_results.size() == 0);
      repeat (40) @(posedge clock);
      $display("%0d requests: %0d find hits, %0d adds, %0d removes, %0d misses",
               n_items, n_hits, n_added, n_removed, n_miss);
      $display("refused adds: %0d duplicate names, %0d on a full table", n_dup, n_full);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
